// ===== design/mfsp_pkg.sv =====
// ---------------------------------------------------------------------------
// mfsp_pkg
// Shared types and constants of the MIDI file stream parser.
// ---------------------------------------------------------------------------
package mfsp_pkg;

    localparam int MAX_DELTA_BYTES_DEF = 4;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [31:0] TAG_MTHD = 32'h4D54_6864;
    localparam logic [31:0] TAG_MTRK = 32'h4D54_726B;

    localparam logic [7:0]  STATUS_META   = 8'hFF;
    localparam logic [31:0] MTHD_BODY_LEN = 32'd6;

    // result kinds
    localparam logic [3:0] KIND_HEADER  = 4'd0;
    localparam logic [3:0] KIND_SKIPPED = 4'd8;
    localparam logic [3:0] KIND_ERROR   = 4'd9;

    // offset from status high nibble to result kind for channel messages
    localparam logic [3:0] KIND_CHAN_OFFSET = 4'd7;

    // channel message status nibbles
    localparam logic [3:0] HI_NOTE_OFF  = 4'b1000;
    localparam logic [3:0] HI_BEND      = 4'b1110;
    localparam logic [3:0] HI_PROGRAM   = 4'b1100;
    localparam logic [3:0] HI_CHAN_PRES = 4'b1101;

    // error codes
    localparam logic [15:0] ERR_BAD_HDR_LEN = 16'd1;
    localparam logic [15:0] ERR_LONG_DELTA  = 16'd2;
    localparam logic [15:0] ERR_TRUNCATED   = 16'd3;

    typedef enum logic [3:0] {
        PH_CHUNK_TYPE,
        PH_CHUNK_LEN,
        PH_HEADER,
        PH_SKIP_CHUNK,
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_META_TYPE,
        PH_SKIP_LEN,
        PH_SKIP_BODY
    } t_phase;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  channel;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [27:0] delta_ticks;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== design/mfsp_parser.sv =====
// ---------------------------------------------------------------------------
// mfsp_parser
// Front end: takes one file byte per cycle while i_take is high, tracks chunk and event state,
// and produces at most one result record for that byte.
// ---------------------------------------------------------------------------
module mfsp_parser #(
    parameter int MAX_DELTA_BYTES = mfsp_pkg::MAX_DELTA_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output mfsp_pkg::t_result o_result
);
    import mfsp_pkg::*;

    localparam logic [3:0] MAX_CNT = 4'(MAX_DELTA_BYTES);

    t_phase      r_phase,       n_phase;
    logic [2:0]  r_byte_pos,    n_byte_pos;
    logic [31:0] r_chunk_kind,  n_chunk_kind;
    logic [31:0] r_chunk_rem,   n_chunk_rem;
    logic [27:0] r_delta_acc,   n_delta_acc;
    logic [2:0]  r_delta_cnt,   n_delta_cnt;
    logic [7:0]  r_status,      n_status;
    logic [7:0]  r_first_data,  n_first_data;
    logic [7:0]  r_meta,        n_meta;
    logic [7:0]  r_skip,        n_skip;
    logic [15:0] r_hdr_fmt,     n_hdr_fmt;
    logic [15:0] r_hdr_trk,     n_hdr_trk;

    logic [31:0] rem_dec;
    logic [31:0] len_new;
    logic [7:0]  skip_dec;
    logic        is_last;
    logic [3:0]  hi;
    t_phase      trk_next;
    logic        emit;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CHUNK_TYPE;
            r_byte_pos   <= '0;
            r_chunk_kind <= '0;
            r_chunk_rem  <= '0;
            r_delta_acc  <= '0;
            r_delta_cnt  <= '0;
            r_status     <= '0;
            r_first_data <= '0;
            r_meta       <= '0;
            r_skip       <= '0;
            r_hdr_fmt    <= '0;
            r_hdr_trk    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_pos   <= n_byte_pos;
            r_chunk_kind <= n_chunk_kind;
            r_chunk_rem  <= n_chunk_rem;
            r_delta_acc  <= n_delta_acc;
            r_delta_cnt  <= n_delta_cnt;
            r_status     <= n_status;
            r_first_data <= n_first_data;
            r_meta       <= n_meta;
            r_skip       <= n_skip;
            r_hdr_fmt    <= n_hdr_fmt;
            r_hdr_trk    <= n_hdr_trk;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_byte_pos   = r_byte_pos;
        n_chunk_kind = r_chunk_kind;
        n_chunk_rem  = r_chunk_rem;
        n_delta_acc  = r_delta_acc;
        n_delta_cnt  = r_delta_cnt;
        n_status     = r_status;
        n_first_data = r_first_data;
        n_meta       = r_meta;
        n_skip       = r_skip;
        n_hdr_fmt    = r_hdr_fmt;
        n_hdr_trk    = r_hdr_trk;

        rem_dec  = (r_chunk_rem != '0) ? r_chunk_rem - 32'd1 : '0;
        is_last  = (rem_dec == '0);
        len_new  = {r_chunk_rem[23:0], i_byte};
        skip_dec = (r_skip != '0) ? r_skip - 8'd1 : '0;
        hi       = r_status[7:4];
        trk_next = PH_DELTA;
        emit     = 1'b0;
        res      = '0;

        if (i_take) begin
            unique case (r_phase) inside
                PH_CHUNK_TYPE: begin
                    n_chunk_kind = {r_chunk_kind[23:0], i_byte};
                    if (r_byte_pos == 3'd3) begin
                        n_byte_pos  = '0;
                        n_chunk_rem = '0;
                        n_phase     = PH_CHUNK_LEN;
                    end else begin
                        n_byte_pos = r_byte_pos + 3'd1;
                    end
                end
                PH_CHUNK_LEN: begin
                    n_chunk_rem = len_new;
                    if (r_byte_pos != 3'd3) begin
                        n_byte_pos = r_byte_pos + 3'd1;
                    end else begin
                        n_byte_pos = '0;
                        if (r_chunk_kind == TAG_MTHD) begin
                            if (len_new == MTHD_BODY_LEN) begin
                                n_phase = PH_HEADER;
                            end else begin
                                emit        = 1'b1;
                                res.kind    = KIND_ERROR;
                                res.value_a = ERR_BAD_HDR_LEN;
                                n_phase = (len_new != '0) ? PH_SKIP_CHUNK : PH_CHUNK_TYPE;
                            end
                        end else if (r_chunk_kind == TAG_MTRK && len_new != '0) begin
                            n_delta_acc = '0;
                            n_delta_cnt = '0;
                            n_phase     = PH_DELTA;
                        end else begin
                            n_phase = (len_new != '0) ? PH_SKIP_CHUNK : PH_CHUNK_TYPE;
                        end
                    end
                end
                PH_HEADER: begin
                    n_byte_pos = r_byte_pos + 3'd1;
                    case (r_byte_pos)
                        3'd0: n_hdr_fmt    = {i_byte, 8'h00};
                        3'd1: n_hdr_fmt    = {r_hdr_fmt[15:8], i_byte};
                        3'd2: n_hdr_trk    = {i_byte, 8'h00};
                        3'd3: n_hdr_trk    = {r_hdr_trk[15:8], i_byte};
                        3'd4: n_first_data = i_byte;
                        default: begin
                            emit        = 1'b1;
                            res.kind    = KIND_HEADER;
                            res.value_a = r_hdr_fmt;
                            res.value_b = r_hdr_trk;
                            res.value_c = {r_first_data, i_byte};
                            n_byte_pos  = '0;
                            n_phase     = PH_CHUNK_TYPE;
                        end
                    endcase
                end
                PH_SKIP_CHUNK: begin
                    n_chunk_rem = rem_dec;
                    if (is_last) begin
                        n_phase = PH_CHUNK_TYPE;
                    end
                end
                PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE, PH_SKIP_LEN,
                PH_SKIP_BODY: begin
                    n_chunk_rem = rem_dec;
                    case (r_phase)
                        PH_DELTA: begin
                            n_delta_acc = {r_delta_acc[20:0], i_byte[6:0]};
                            if (i_byte[7] && ({1'b0, r_delta_cnt} + 4'd1 >= MAX_CNT)) begin
                                emit        = 1'b1;
                                res.kind    = KIND_ERROR;
                                res.value_a = ERR_LONG_DELTA;
                                trk_next    = PH_SKIP_CHUNK;
                            end else begin
                                n_delta_cnt = r_delta_cnt + 3'd1;
                                trk_next    = i_byte[7] ? PH_DELTA : PH_STATUS;
                            end
                        end
                        PH_STATUS: begin
                            n_status = i_byte;
                            if (i_byte[7:4] >= HI_NOTE_OFF && i_byte[7:4] <= HI_BEND) begin
                                trk_next = PH_DATA1;
                            end else if (i_byte == STATUS_META) begin
                                trk_next = PH_META_TYPE;
                            end else begin
                                trk_next = PH_SKIP_LEN;
                            end
                        end
                        PH_DATA1: begin
                            n_first_data = i_byte;
                            if (hi == HI_PROGRAM || hi == HI_CHAN_PRES) begin
                                emit            = 1'b1;
                                res.kind        = hi - KIND_CHAN_OFFSET;
                                res.channel     = r_status[3:0];
                                res.value_a     = {8'h00, i_byte};
                                res.delta_ticks = r_delta_acc;
                            end else begin
                                trk_next = PH_DATA2;
                            end
                        end
                        PH_DATA2: begin
                            emit            = 1'b1;
                            res.kind        = hi - KIND_CHAN_OFFSET;
                            res.channel     = r_status[3:0];
                            res.value_a     = {8'h00, r_first_data};
                            res.value_b     = {8'h00, i_byte};
                            res.delta_ticks = r_delta_acc;
                        end
                        PH_META_TYPE: begin
                            n_meta   = i_byte;
                            trk_next = PH_SKIP_LEN;
                        end
                        PH_SKIP_LEN: begin
                            n_skip       = i_byte;
                            n_first_data = i_byte;
                            if (i_byte == 8'h00) begin
                                emit = 1'b1;
                            end else begin
                                trk_next = PH_SKIP_BODY;
                            end
                        end
                        default: begin
                            n_skip = skip_dec;
                            if (skip_dec == 8'h00) begin
                                emit = 1'b1;
                            end else begin
                                trk_next = PH_SKIP_BODY;
                            end
                        end
                    endcase

                    // skipped event report: status, length, meta type
                    if (emit && (r_phase == PH_SKIP_LEN || r_phase == PH_SKIP_BODY)) begin
                        res.kind        = KIND_SKIPPED;
                        res.value_a     = {8'h00, r_status};
                        res.value_b     = (r_phase == PH_SKIP_LEN) ? 16'h0000
                                                                   : {8'h00, r_first_data};
                        res.value_c     = (r_status == STATUS_META) ? {8'h00, r_meta}
                                                                    : 16'h0000;
                        res.delta_ticks = r_delta_acc;
                    end

                    if (is_last) begin
                        // chunk ran out: report truncation unless a result is already due
                        if (!emit) begin
                            emit        = 1'b1;
                            res         = '0;
                            res.kind    = KIND_ERROR;
                            res.value_a = ERR_TRUNCATED;
                        end
                        n_phase = PH_CHUNK_TYPE;
                    end else begin
                        if (trk_next == PH_DELTA && r_phase != PH_DELTA) begin
                            n_delta_acc = '0;
                            n_delta_cnt = '0;
                        end
                        n_phase = trk_next;
                    end
                end
                default: begin
                    n_phase    = PH_CHUNK_TYPE;
                    n_byte_pos = '0;
                end
            endcase
        end

        o_push   = emit;
        o_result = res;
    end

endmodule

// ===== design/mfsp_queue.sv =====
// ---------------------------------------------------------------------------
// mfsp_queue
// Short result queue between the parser and the output stage.
// ---------------------------------------------------------------------------
module mfsp_queue #(
    parameter int DEPTH = mfsp_pkg::QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  mfsp_pkg::t_result       i_data,
    input  logic                    i_pop,
    output mfsp_pkg::t_result       o_data,
    output mfsp_pkg::t_queue_status o_status
);
    import mfsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CNT_FULL);
    assign o_status.empty = (r_cnt == '0);

endmodule

// ===== design/mfsp_emitter.sv =====
// ---------------------------------------------------------------------------
// mfsp_emitter
// Back end: moves queued results into the output register and packs them
// onto the result stream.
// ---------------------------------------------------------------------------
module mfsp_emitter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mfsp_pkg::t_result       i_data,
    input  mfsp_pkg::t_queue_status i_status,
    output logic                    o_pop,
    output logic                    o_tvalid,
    input  logic                    i_tready,
    output logic [79:0]             o_tdata,
    output logic [3:0]              o_tuser
);
    import mfsp_pkg::*;

    logic    r_valid;
    t_result r_data;

    // refill when the register is empty or its request goes out this cycle
    assign o_pop = !i_status.empty && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_tready) begin
            r_valid <= !i_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_data.kind;
    assign o_tdata  = {r_data.delta_ticks, r_data.value_c, r_data.value_b,
                       r_data.value_a, r_data.channel};

endmodule

// ===== design/midi_file_stream_parser.sv =====
// ---------------------------------------------------------------------------
// midi_file_stream_parser
// Standard MIDI File byte stream parser with a decoupled result stream.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries the raw file, one byte per request in tdata.
//   Master stream carries parsed results: tuser is the event kind (header,
//   channel messages, skipped meta/sysex, error), tdata packs channel,
//   value_a, value_b, value_c and delta_ticks.
//   Throughput: one byte per cycle while the queue has room. Every byte
//   updates the registered parser state, so consecutive requests are taken
//   back to back.
//   Path: a result caused by a byte is written into the queue at the
//   edge that accepts that byte, then loaded into the output register
//   when that register is empty or its request goes out, and from there
//   it is valid on the master side.
//   Stall: the output register holds its request while tready is low; the
//   two-entry queue keeps absorbing results, and the slave tready drops
//   only once the queue is full, so the input side sees backpressure a
//   couple of results after the master side stops.
//   Reset: synchronous, active low. Clears the parser to "expect chunk
//   type", empties the queue and drops master tvalid. No clearing pass.
// ---------------------------------------------------------------------------
module midi_file_stream_parser #(
    parameter int MAX_DELTA_BYTES = mfsp_pkg::MAX_DELTA_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] stream_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [3:0] channel, [19:4] value_a,
                                          // [35:20] value_b, [51:36] value_c,
                                          // [79:52] delta_ticks
    output logic [3:0]  o_m_axis_tuser    // [3:0] event_kind
);
    import mfsp_pkg::*;

    logic          take;
    logic          push;
    logic          pop;
    t_result       parsed;
    t_result       queued;
    t_queue_status q_status;

    // accept a byte whenever the queue has room for its possible result
    assign o_s_axis_tready = !q_status.full;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    // front: classify each byte and build its result
    mfsp_parser #(
        .MAX_DELTA_BYTES (MAX_DELTA_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_s_axis_tdata),
        .o_push   (push),
        .o_result (parsed)
    );

    // decouple parser from the output handshake
    mfsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (parsed),
        .i_pop    (pop),
        .o_data   (queued),
        .o_status (q_status)
    );

    // back: hold and present results on the master stream
    mfsp_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (queued),
        .i_status (q_status),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== design/mfsp_checker.sv =====
// ---------------------------------------------------------------------------
// mfsp_checker
// Port-level checks on the MIDI file stream parser, bound to the top level.
// ---------------------------------------------------------------------------
module mfsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata,
    input logic [3:0]  o_m_axis_tuser
);
    import mfsp_pkg::*;

    // reset empties the output side and opens the input side
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_reset_in: assert property (@(posedge i_clk) !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= KIND_ERROR)
        else $error("event kind out of range");

    // header and error results carry no channel and no delta time
    a_no_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_HEADER || o_m_axis_tuser == KIND_ERROR)
            |-> o_m_axis_tdata[79:52] == '0 && o_m_axis_tdata[3:0] == '0)
        else $error("header or error result with channel or delta");

endmodule

bind midi_file_stream_parser mfsp_checker u_mfsp_checker (.*);

// ===== tb/sv/tb_midi_file_stream_parser.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_midi_file_stream_parser
// Feeds MIDI file byte streams into the parser and checks every result
// against a cycle-free parser kept in the bench, under random sender gaps,
// random receiver stalls and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_midi_file_stream_parser;
    import mfsp_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_BYTES    = 640;
    localparam int DELTA_LIMIT     = MAX_DELTA_BYTES_DEF;

    // status nibbles and bytes the package leaves unnamed
    localparam logic [3:0] HI_NOTE_ON     = 4'b1001;
    localparam logic [3:0] HI_KEY_PRES    = 4'b1010;
    localparam logic [3:0] HI_CONTROL     = 4'b1011;
    localparam logic [7:0] STATUS_SYSEX   = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE  = 8'hF7;
    localparam logic [7:0] STATUS_STRAY   = 8'h45;
    localparam logic [7:0] META_END_TRACK = 8'h2F;
    localparam logic [7:0] META_TEMPO     = 8'h51;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = 8'h00;   // [7:0] stream_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [79:0] o_m_axis_tdata;            // [3:0] channel, [19:4] value_a,
                                            // [35:20] value_b, [51:36] value_c,
                                            // [79:52] delta_ticks
    logic [3:0]  o_m_axis_tuser;            // [3:0] event_kind

    midi_file_stream_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Parser mirror: one call per accepted byte, same state as after reset.
    // -----------------------------------------------------------------------
    t_phase      mirror_phase  = PH_CHUNK_TYPE;
    logic [2:0]  header_pos    = '0;
    logic [31:0] chunk_tag     = '0;
    logic [31:0] chunk_left    = '0;
    logic [27:0] delta_sum     = '0;
    logic [2:0]  delta_bytes   = '0;
    logic [7:0]  status_byte   = '0;
    logic [7:0]  held_byte     = '0;   // first data byte, division high, skip length
    logic [7:0]  meta_type     = '0;
    logic [7:0]  body_left     = '0;
    logic [15:0] smf_format    = '0;
    logic [15:0] smf_tracks    = '0;

    t_result     pending_events[$];
    int          mismatch_count = 0;
    int          result_count   = 0;
    int          cycle_count    = 0;

    function automatic t_result make_result(input logic [3:0] kind, input logic [3:0] chan,
                                            input logic [15:0] va, input logic [15:0] vb,
                                            input logic [15:0] vc, input logic [27:0] ticks);
        return {kind, chan, va, vb, vc, ticks};
    endfunction

    task automatic parse_byte(input logic [7:0] data, output bit got, output t_result res);
        t_phase     nxt;
        logic [3:0] hi;
        bit         at_end;
        got = 1'b0;
        res = '0;
        if (mirror_phase >= PH_DELTA && mirror_phase <= PH_SKIP_BODY) begin
            // Track body: every byte uses up one byte of the chunk length.
            nxt = PH_DELTA;
            hi  = status_byte[7:4];
            if (chunk_left != 0)
                chunk_left--;
            at_end = (chunk_left == 0);
            case (mirror_phase)
                PH_DELTA: begin
                    delta_sum = {delta_sum[20:0], data[6:0]};
                    if (data[7] && int'(delta_bytes) + 1 >= DELTA_LIMIT) begin
                        got = 1'b1;
                        res = make_result(KIND_ERROR, 4'd0, ERR_LONG_DELTA, 16'd0, 16'd0, 28'd0);
                        nxt = PH_SKIP_CHUNK;
                    end else begin
                        delta_bytes++;
                        nxt = data[7] ? PH_DELTA : PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    status_byte = data;
                    hi = data[7:4];
                    if (hi >= HI_NOTE_OFF && hi <= HI_BEND)
                        nxt = PH_DATA1;
                    else if (data == STATUS_META)
                        nxt = PH_META_TYPE;
                    else
                        nxt = PH_SKIP_LEN;
                end
                PH_DATA1: begin
                    held_byte = data;
                    if (hi == HI_PROGRAM || hi == HI_CHAN_PRES) begin
                        got = 1'b1;
                        res = make_result(hi - KIND_CHAN_OFFSET, status_byte[3:0], {8'd0, data},
                                          16'd0, 16'd0, delta_sum);
                    end else begin
                        nxt = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    got = 1'b1;
                    res = make_result(hi - KIND_CHAN_OFFSET, status_byte[3:0], {8'd0, held_byte},
                                      {8'd0, data}, 16'd0, delta_sum);
                end
                PH_META_TYPE: begin
                    meta_type = data;
                    nxt = PH_SKIP_LEN;
                end
                PH_SKIP_LEN: begin
                    body_left = data;
                    held_byte = data;
                    if (data == 0) begin
                        got = 1'b1;
                        res = make_result(KIND_SKIPPED, 4'd0, {8'd0, status_byte}, 16'd0,
                                          (status_byte == STATUS_META) ? {8'd0, meta_type} : 16'd0,
                                          delta_sum);
                    end else begin
                        nxt = PH_SKIP_BODY;
                    end
                end
                default: begin
                    if (body_left != 0)
                        body_left--;
                    if (body_left == 0) begin
                        got = 1'b1;
                        res = make_result(KIND_SKIPPED, 4'd0, {8'd0, status_byte},
                                          {8'd0, held_byte},
                                          (status_byte == STATUS_META) ? {8'd0, meta_type} : 16'd0,
                                          delta_sum);
                    end else begin
                        nxt = PH_SKIP_BODY;
                    end
                end
            endcase
            if (at_end) begin
                // Chunk ran out: anything unfinished is reported as truncated.
                if (!got) begin
                    got = 1'b1;
                    res = make_result(KIND_ERROR, 4'd0, ERR_TRUNCATED, 16'd0, 16'd0, 28'd0);
                end
                mirror_phase = PH_CHUNK_TYPE;
            end else begin
                if (nxt == PH_DELTA && mirror_phase != PH_DELTA) begin
                    delta_sum   = '0;
                    delta_bytes = '0;
                end
                mirror_phase = nxt;
            end
        end else begin
            case (mirror_phase)
                PH_CHUNK_TYPE: begin
                    chunk_tag = {chunk_tag[23:0], data};
                    header_pos++;
                    if (header_pos >= 4) begin
                        header_pos   = '0;
                        chunk_left   = '0;
                        mirror_phase = PH_CHUNK_LEN;
                    end
                end
                PH_CHUNK_LEN: begin
                    chunk_left = {chunk_left[23:0], data};
                    header_pos++;
                    if (header_pos >= 4) begin
                        header_pos = '0;
                        if (chunk_tag == TAG_MTHD) begin
                            if (chunk_left == MTHD_BODY_LEN) begin
                                mirror_phase = PH_HEADER;
                            end else begin
                                got = 1'b1;
                                res = make_result(KIND_ERROR, 4'd0, ERR_BAD_HDR_LEN, 16'd0,
                                                  16'd0, 28'd0);
                                mirror_phase = (chunk_left != 0) ? PH_SKIP_CHUNK : PH_CHUNK_TYPE;
                            end
                        end else if (chunk_tag == TAG_MTRK && chunk_left != 0) begin
                            delta_sum    = '0;
                            delta_bytes  = '0;
                            mirror_phase = PH_DELTA;
                        end else begin
                            mirror_phase = (chunk_left != 0) ? PH_SKIP_CHUNK : PH_CHUNK_TYPE;
                        end
                    end
                end
                PH_HEADER: begin
                    case (header_pos)
                        3'd0: smf_format = {data, 8'd0};
                        3'd1: smf_format[7:0] = data;
                        3'd2: smf_tracks = {data, 8'd0};
                        3'd3: smf_tracks[7:0] = data;
                        3'd4: held_byte = data;
                        default: begin
                            got = 1'b1;
                            res = make_result(KIND_HEADER, 4'd0, smf_format, smf_tracks,
                                              {held_byte, data}, 28'd0);
                        end
                    endcase
                    if (got) begin
                        header_pos   = '0;
                        mirror_phase = PH_CHUNK_TYPE;
                    end else begin
                        header_pos++;
                    end
                end
                PH_SKIP_CHUNK: begin
                    if (chunk_left != 0)
                        chunk_left--;
                    if (chunk_left == 0)
                        mirror_phase = PH_CHUNK_TYPE;
                end
                default: begin
                    mirror_phase = PH_CHUNK_TYPE;
                    header_pos   = '0;
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("[%0t] result %0d: %s is %0h, expected %0h", $realtime, result_count, what,
                 seen, wanted);
        mismatch_count++;
    endtask

    // -----------------------------------------------------------------------
    // Monitor: predict on every accepted byte, check on every accepted result.
    // A byte's result passes through the queue and the output register first, so both fit in one block.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        bit      got;
        t_result res;
        t_result want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                parse_byte(i_s_axis_tdata, got, res);
                if (got)
                    pending_events.push_back(res);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_events.size() == 0) begin
                    report_mismatch("unexpected result, kind", 32'(o_m_axis_tuser), 32'd0);
                end else begin
                    want = pending_events.pop_front();
                    if (o_m_axis_tuser != want.kind)
                        report_mismatch("event_kind", 32'(o_m_axis_tuser), 32'(want.kind));
                    if (o_m_axis_tdata[3:0] != want.channel)
                        report_mismatch("channel", 32'(o_m_axis_tdata[3:0]),
                                        32'(want.channel));
                    if (o_m_axis_tdata[19:4] != want.value_a)
                        report_mismatch("value_a", 32'(o_m_axis_tdata[19:4]),
                                        32'(want.value_a));
                    if (o_m_axis_tdata[35:20] != want.value_b)
                        report_mismatch("value_b", 32'(o_m_axis_tdata[35:20]),
                                        32'(want.value_b));
                    if (o_m_axis_tdata[51:36] != want.value_c)
                        report_mismatch("value_c", 32'(o_m_axis_tdata[51:36]),
                                        32'(want.value_c));
                    if (o_m_axis_tdata[79:52] != want.delta_ticks)
                        report_mismatch("delta_ticks", 32'(o_m_axis_tdata[79:52]),
                                        32'(want.delta_ticks));
                end
                result_count++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_midi_file_stream_parser NOT OK");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: stall modes of random length; a hold-off request from a test
    // drops tready for a long counted stretch so the parser backs up.
    // -----------------------------------------------------------------------
    bit hold_off_req = 1'b0;
    int hold_left    = 0;
    int rx_mode      = 0;
    int mode_left    = 0;

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0:       i_m_axis_tready <= 1'b1;
                1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Sender: bursts of requests with random gaps between them.
    // Entered and left at a falling edge.
    // -----------------------------------------------------------------------
    int          burst_left = 0;
    int          bytes_sent = 0;
    logic [7:0]  chunk_body[$];

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                i_s_axis_tdata  <= 8'($urandom_range(0, 255));
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Send chunk header and body; a cut below the body size truncates it.
    task automatic send_chunk(input logic [31:0] tag, input int cut);
        logic [31:0] len;
        len = (cut < 0) ? chunk_body.size() : cut;
        for (int i = 3; i >= 0; i--)
            send_byte(tag[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            send_byte(len[8*i +: 8]);
        for (int i = 0; i < int'(len); i++)
            send_byte(chunk_body[i]);
        chunk_body.delete();
    endtask

    // Emit the delta in exactly nbytes groups, padding with leading zero groups.
    task automatic push_delta(input logic [27:0] ticks, input int nbytes);
        logic [7:0] group;
        for (int i = nbytes - 1; i >= 0; i--) begin
            group = 8'((ticks >> (7 * i)) & 28'h7F);
            if (i != 0)
                group[7] = 1'b1;
            chunk_body.push_back(group);
        end
    endtask

    task automatic push_channel(input logic [7:0] status, input logic [7:0] d1,
                                input logic [7:0] d2);
        chunk_body.push_back(status);
        chunk_body.push_back(d1);
        if (status[7:4] != HI_PROGRAM && status[7:4] != HI_CHAN_PRES)
            chunk_body.push_back(d2);
    endtask

    task automatic push_skip(input logic [7:0] status, input logic [7:0] mtype,
                             input logic [7:0] len);
        chunk_body.push_back(status);
        if (status == STATUS_META)
            chunk_body.push_back(mtype);
        chunk_body.push_back(len);
        repeat (len) chunk_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // -----------------------------------------------------------------------
    // Directed tests
    // -----------------------------------------------------------------------
    task automatic test_header();
        chunk_body = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hE7, 8'h28};
        send_chunk(TAG_MTHD, -1);
    endtask

    // Header length other than six: zero length, then a short body to skip.
    task automatic test_bad_header_length();
        send_chunk(TAG_MTHD, -1);
        chunk_body = '{8'hAA, 8'h55};
        send_chunk(TAG_MTHD, -1);
    endtask

    // Empty track and unknown chunks pass without results.
    task automatic test_empty_chunks();
        send_chunk(TAG_MTRK, -1);
        send_chunk(32'h5859_5A57, -1);
        chunk_body = '{8'h90, 8'h3C, 8'h40};
        send_chunk(32'h4A55_4E4B, -1);
    endtask

    task automatic test_channel_messages();
        push_delta(28'd0, 1);
        push_channel({HI_NOTE_OFF, 4'h0}, 8'h00, 8'h00);
        push_delta(28'h0FFFFFF, 4);
        push_channel({HI_NOTE_ON, 4'hF}, 8'hFF, 8'h80);   // data bytes pass unmasked
        push_delta(28'd5, 1);
        push_channel({HI_KEY_PRES, 4'h3}, 8'h7F, 8'h01);
        push_delta(28'd128, 2);
        push_channel({HI_CONTROL, 4'h9}, 8'h07, 8'h64);
        push_delta(28'd0, 3);
        push_channel({HI_PROGRAM, 4'h5}, 8'h80, 8'h00);
        push_delta(28'd1, 1);
        push_channel({HI_CHAN_PRES, 4'h2}, 8'h55, 8'h00);
        push_delta(28'hFFFFFFF, 4);
        push_channel({HI_BEND, 4'hA}, 8'h00, 8'h40);
        send_chunk(TAG_MTRK, -1);
    endtask

    // Meta, sysex, escape and a stray data byte in status position.
    task automatic test_skipped_events();
        push_delta(28'd0, 1);
        push_skip(STATUS_META, META_END_TRACK, 8'd0);
        push_delta(28'd3, 1);
        push_skip(STATUS_META, META_TEMPO, 8'd3);
        push_delta(28'd0, 1);
        push_skip(STATUS_SYSEX, 8'd0, 8'd2);
        push_delta(28'd0, 1);
        push_skip(STATUS_STRAY, 8'd0, 8'd1);
        push_delta(28'd9, 1);
        push_skip(STATUS_ESCAPE, 8'd0, 8'd0);
        send_chunk(TAG_MTRK, -1);
    endtask

    // Too many continuation bytes: error, then the rest of the track is dropped.
    task automatic test_long_delta();
        push_delta(28'd0, 1);
        push_channel({HI_NOTE_ON, 4'h1}, 8'h3C, 8'h40);
        repeat (DELTA_LIMIT) chunk_body.push_back(8'h80);
        push_channel({HI_NOTE_ON, 4'h1}, 8'h3C, 8'h00);
        send_chunk(TAG_MTRK, -1);
    endtask

    // Track length runs out mid-event: in data, in a skip body, in a delta.
    task automatic test_truncated_track();
        push_delta(28'd0, 1);
        push_channel({HI_NOTE_ON, 4'h0}, 8'h3C, 8'h40);
        send_chunk(TAG_MTRK, 3);
        push_delta(28'd0, 1);
        push_skip(STATUS_META, META_TEMPO, 8'd5);
        send_chunk(TAG_MTRK, 5);
        push_delta(28'd200, 2);
        push_channel({HI_CONTROL, 4'h0}, 8'h01, 8'h02);
        send_chunk(TAG_MTRK, 1);
    endtask

    // Receiver holds off while a dense track keeps coming; input must stall.
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int i = 0; i < 32; i++) begin
            push_delta(28'(i), 1);
            push_channel({HI_NOTE_ON, i[3:0]}, 8'($urandom_range(0, 127)),
                         8'($urandom_range(0, 127)));
        end
        send_chunk(TAG_MTRK, -1);
    endtask

    // -----------------------------------------------------------------------
    // Random files: mostly well-formed tracks, some truncated, some noise.
    // -----------------------------------------------------------------------
    task automatic add_random_event();
        int         pick;
        int         nbytes;
        logic [7:0] len;
        nbytes = $urandom_range(1, DELTA_LIMIT);
        pick   = $urandom_range(0, 99);
        len    = ($urandom_range(0, 59) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
        if (pick < 4) begin
            repeat (DELTA_LIMIT) chunk_body.push_back(8'h80 | 8'($urandom_range(0, 127)));
            chunk_body.push_back(8'($urandom_range(0, 255)));
        end else begin
            push_delta(28'($urandom & ((32'd1 << (7 * nbytes)) - 1)), nbytes);
            if (pick < 74)
                push_channel({4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))},
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else if (pick < 86)
                push_skip(STATUS_META, 8'($urandom_range(0, 255)), len);
            else if (pick < 93)
                push_skip($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE, 8'd0, len);
            else
                push_skip($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                               : 8'($urandom_range(8'hF1, 8'hFE)), 8'd0, len);
        end
    endtask

    task automatic add_random_chunk();
        int          pick;
        int          cut;
        int          len;
        logic [31:0] tag;
        pick = $urandom_range(0, 99);
        cut  = -1;
        if (pick < 72) begin
            repeat ($urandom_range(1, 10)) add_random_event();
            if ($urandom_range(0, 4) == 0 && chunk_body.size() > 1)
                cut = $urandom_range(1, chunk_body.size() - 1);
            send_chunk(TAG_MTRK, cut);
        end else if (pick < 82) begin
            len = 6;
            if ($urandom_range(0, 2) == 0) begin
                len = $urandom_range(0, 8);
                if (len >= 6)
                    len++;
            end
            repeat (len) chunk_body.push_back(8'($urandom_range(0, 255)));
            send_chunk(TAG_MTHD, -1);
        end else if (pick < 95) begin
            tag = $urandom_range(0, 1) ? $urandom : (TAG_MTRK ^ (32'd1 << $urandom_range(0, 31)));
            if (tag == TAG_MTRK || tag == TAG_MTHD)
                tag[0] = ~tag[0];
            repeat ($urandom_range(0, 5)) chunk_body.push_back(8'($urandom_range(0, 255)));
            send_chunk(tag, -1);
        end else begin
            send_chunk(TAG_MTRK, -1);
        end
    endtask

    task automatic test_random_files();
        int start;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
            add_random_chunk();
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_header();
        test_bad_header_length();
        test_empty_chunks();
        test_channel_messages();
        test_skipped_events();
        test_long_delta();
        test_truncated_track();
        test_backpressure();
        test_random_files();

        // Stop requesting, wait for the last results, then allow the pipeline to settle.
        i_s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb_midi_file_stream_parser OK");
        else
            $display("tb_midi_file_stream_parser NOT OK");
        $finish;
    end

endmodule

// ===== midi_file_stream_parser.f =====
design/mfsp_pkg.sv
design/mfsp_parser.sv
design/mfsp_queue.sv
design/mfsp_emitter.sv
design/midi_file_stream_parser.sv
design/mfsp_checker.sv
tb/sv/tb_midi_file_stream_parser.sv
